// ===== design/bfgr_pkg.sv =====
package bfgr_pkg;

  // Configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_START_X     = 3'd0;
  localparam logic [2:0] REG_START_Y     = 3'd1;
  localparam logic [2:0] REG_DRAW_COLOR  = 3'd2;
  localparam logic [2:0] REG_FIRST_CHAR  = 3'd3;
  localparam logic [2:0] REG_FONT_HEIGHT = 3'd4;
  localparam logic [2:0] REG_USE_TABLE   = 3'd5;

  localparam logic [7:0] FIRST_CHAR_RST  = 8'd32;
  localparam logic [4:0] FONT_HEIGHT_RST = 5'd8;

  // Item kinds
  localparam logic [1:0] KIND_LOAD_ENTRY = 2'd0;
  localparam logic [1:0] KIND_LOAD_GLYPH = 2'd1;
  localparam logic [1:0] KIND_DRAW       = 2'd2;

  localparam logic [5:0] FIXED_WIDTH   = 6'd5;
  localparam int         BITS_PER_BYTE = 8;
  localparam int         RESULT_CAP    = 32;
  localparam int         CAP_W         = 5;
  localparam int         OFF_W         = 12;

  typedef struct packed {
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [15:0] draw_color;
    logic [7:0]  first_char;
    logic [4:0]  font_height;
    logic        use_char_table;
  } cfg_t;

endpackage

// ===== design/bfgr_cfg_regs.sv =====
module bfgr_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bfgr_pkg::ADDR_W-1:0]   paddr,
  input  logic [bfgr_pkg::DATA_W-1:0]   pwdata,
  output logic [bfgr_pkg::DATA_W-1:0]   prdata,
  output bfgr_pkg::cfg_t                cfg
);
  import bfgr_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_x        <= '0;
      cfg.start_y        <= '0;
      cfg.draw_color     <= '0;
      cfg.first_char     <= FIRST_CHAR_RST;
      cfg.font_height    <= FONT_HEIGHT_RST;
      cfg.use_char_table <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_START_X:     cfg.start_x        <= pwdata[15:0];
        REG_START_Y:     cfg.start_y        <= pwdata[15:0];
        REG_DRAW_COLOR:  cfg.draw_color     <= pwdata[15:0];
        REG_FIRST_CHAR:  cfg.first_char     <= pwdata[7:0];
        REG_FONT_HEIGHT: cfg.font_height    <= pwdata[4:0];
        REG_USE_TABLE:   cfg.use_char_table <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_START_X:     prdata = DATA_W'(cfg.start_x);
      REG_START_Y:     prdata = DATA_W'(cfg.start_y);
      REG_DRAW_COLOR:  prdata = DATA_W'(cfg.draw_color);
      REG_FIRST_CHAR:  prdata = DATA_W'(cfg.first_char);
      REG_FONT_HEIGHT: prdata = DATA_W'(cfg.font_height);
      REG_USE_TABLE:   prdata = DATA_W'(cfg.use_char_table);
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== design/bitmap_font_glyph_renderer_top.sv =====
// Bitmap font character generator.
// Configuration: APB-style register port (start_x, start_y, draw_color,
// first_char, font_height, use_char_table at byte addresses 0..20), to be
// written only while the block is idle (not enforced); pready is tied high.
// Input channel (in_valid/in_ready): kind 0 writes a character table entry,
// kind 1 writes a glyph byte; both give no result and leave the block idle.
// Kind 2 draws a character: one result per glyph byte, rows top to bottom,
// byte-columns left to right, last set on the final one. An unknown code or
// an empty glyph gives a single result.
// Draw sequence: accept, table lookup, then a reduce state in which a shared
// compare/subtract unit folds the glyph offset into the glyph store in R steps
// (R = 13 - clog2(GLYPH_BYTES), 0 when negative; R = 1 at the default size),
// then one result per cycle from the glyph store read port while the receiver
// is ready. A single-result character goes from the lookup to its result.
// in_ready is low for the whole draw and returns high once the last result
// sits in the output register, so the next item overlaps its hand-off.
// A stalled receiver holds the output register and the result sequence.
// Reset clears the config registers, cursor and string width; tables and glyph
// store are not cleared and must be loaded before they are drawn from.
module bitmap_font_glyph_renderer_top #(
  parameter int CHAR_TABLE_DEPTH = 128,
  parameter int GLYPH_BYTES      = 4096,
  parameter int MAX_GLYPH_HEIGHT = 16,
  parameter int MAX_GLYPH_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bfgr_pkg::ADDR_W-1:0]   paddr,
  input  logic [bfgr_pkg::DATA_W-1:0]   pwdata,
  output logic [bfgr_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    kind,
  input  logic [7:0]                    char_code,
  input  logic                          new_string,
  input  logic [6:0]                    entry_index,
  input  logic [4:0]                    entry_width,
  input  logic [11:0]                   entry_offset,
  input  logic [11:0]                   data_address,
  input  logic [7:0]                    data_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [15:0]                   pixel_x,
  output logic [15:0]                   pixel_y,
  output logic [7:0]                    pixel_mask,
  output logic [15:0]                   pixel_color,
  output logic [15:0]                   string_width,
  output logic                          bad_char,
  output logic                          last
);
  import bfgr_pkg::*;

  localparam int TIW = (CHAR_TABLE_DEPTH > 1) ? $clog2(CHAR_TABLE_DEPTH) : 1;
  localparam int AW  = $clog2(GLYPH_BYTES);
  localparam int RED_STEPS = (AW >= OFF_W + 1) ? 0 : OFF_W + 1 - AW;
  localparam int STEP_W = (RED_STEPS > 0) ? $clog2(RED_STEPS + 1) : 1;
  localparam int DIV_W  = OFF_W + 1;
  localparam longint DIV_INIT_L = (longint'(GLYPH_BYTES) << RED_STEPS) >> 1;
  localparam logic [DIV_W-1:0] DIV_INIT = DIV_W'(DIV_INIT_L);
  localparam int WW = $clog2(MAX_GLYPH_WIDTH + 1);
  localparam int HW = $clog2(MAX_GLYPH_HEIGHT + 1);
  localparam logic [5:0]    MAXW6  = 6'(MAX_GLYPH_WIDTH);
  localparam logic [5:0]    MAXH6  = 6'(MAX_GLYPH_HEIGHT);
  localparam logic [8:0]    DEPTH9 = 9'(CHAR_TABLE_DEPTH);
  localparam logic [16:0]   GB17   = 17'(GLYPH_BYTES);
  localparam logic [AW-1:0] G_LAST = AW'(GLYPH_BYTES - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOOKUP = 3'd1;
  localparam logic [2:0] S_REDUCE = 3'd2;
  localparam logic [2:0] S_EMIT   = 3'd3;
  localparam logic [2:0] S_SINGLE = 3'd4;

  cfg_t cfg;

  bfgr_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  logic [2:0] state;

  // Storage
  logic [4:0]       width_mem  [CHAR_TABLE_DEPTH];
  logic [OFF_W-1:0] offset_mem [CHAR_TABLE_DEPTH];
  logic [7:0]       glyph_mem  [GLYPH_BYTES];
  logic [4:0]       tw_q;
  logic [OFF_W-1:0] to_q;
  logic [7:0]       gdata;

  logic             accept;
  logic             tbl_we;
  logic             g_we;
  logic [8:0]       idx9;
  logic [8:0]       rel9;
  logic [16:0]      ga17;
  logic [7:0]       in_rel;
  logic             in_bad;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign idx9     = {2'b00, entry_index};
  assign ga17     = {5'b00000, data_address};
  assign in_rel   = char_code - cfg.first_char;
  assign rel9     = {1'b0, in_rel};
  assign in_bad   = (char_code < cfg.first_char) || (rel9 >= DEPTH9);
  assign tbl_we   = accept && (kind == KIND_LOAD_ENTRY) && (idx9 < DEPTH9);
  assign g_we     = accept && (kind == KIND_LOAD_GLYPH) && (ga17 < GB17);

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      width_mem[idx9[TIW-1:0]]  <= entry_width;
      offset_mem[idx9[TIW-1:0]] <= entry_offset;
    end
    tw_q <= width_mem[rel9[TIW-1:0]];
    to_q <= offset_mem[rel9[TIW-1:0]];
  end

  // Sequencer registers
  logic [15:0]       cursor;
  logic [15:0]       acc;
  logic [7:0]        rel_q;
  logic              bad_q;
  logic              single_bad;
  logic [WW-1:0]     width_q;
  logic [HW-1:0]     height_q;
  logic [2:0]        pages_q;
  logic [OFF_W-1:0]  red;
  logic [DIV_W-1:0]  div;
  logic [STEP_W-1:0] step;
  logic [AW-1:0]     addr;
  logic [AW-1:0]     addr_next;
  logic [4:0]        row;
  logic [1:0]        col;
  logic [CAP_W-1:0]  n;
  logic [15:0]       xpos;
  logic [15:0]       ypos;

  // Glyph lookup values
  logic [5:0]       w6;
  logic [5:0]       wsat6;
  logic [5:0]       h6;
  logic [5:0]       hsat6;
  logic [5:0]       p6;
  logic [2:0]       pages3;
  logic [OFF_W-1:0] offset_sel;
  logic             is_single;

  assign w6         = cfg.use_char_table ? {1'b0, tw_q} : FIXED_WIDTH;
  assign wsat6      = (w6 > MAXW6) ? MAXW6 : w6;
  assign h6         = {1'b0, cfg.font_height};
  assign hsat6      = (h6 > MAXH6) ? MAXH6 : h6;
  assign p6         = (wsat6 + 6'd7) >> 3;
  assign pages3     = p6[2:0];
  assign offset_sel = cfg.use_char_table ? to_q
                                         : (OFF_W'({rel_q, 2'b00}) + OFF_W'(rel_q));
  assign is_single  = bad_q || (pages3 == 3'd0) || (hsat6 == 6'd0);

  // Shared compare/subtract unit for offset folding
  logic             red_ge;
  logic [DIV_W-1:0] red_diff;
  logic [16:0]      red17;

  assign red_ge   = ({1'b0, red} >= div);
  assign red_diff = {1'b0, red} - div;
  assign red17    = 17'(red);

  // Result generation
  logic             row_last;
  logic             col_last;
  logic             emit_last;
  logic             out_load;
  logic [15:0]      sw;

  assign row_last  = (6'(row) + 6'd1) == 6'(height_q);
  assign col_last  = (3'(col) + 3'd1) == pages_q;
  assign emit_last = (n == CAP_W'(RESULT_CAP - 1)) || (row_last && col_last);
  assign out_load  = ((state == S_EMIT) || (state == S_SINGLE)) &&
                     (!out_valid || out_ready);
  assign sw        = (acc == 16'd0) ? 16'd0 : acc - 16'd1;

  always_comb begin
    addr_next = addr;
    if ((state == S_REDUCE) && (step == '0)) begin
      addr_next = red17[AW-1:0];
    end else if ((state == S_EMIT) && out_load && !emit_last) begin
      addr_next = (addr == G_LAST) ? '0 : addr + AW'(1);
    end
  end

  // Read follows the next address so gdata always matches addr
  always_ff @(posedge clk) begin
    if (g_we) begin
      glyph_mem[ga17[AW-1:0]] <= data_byte;
    end
    gdata <= glyph_mem[addr_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cursor    <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && (kind == KIND_DRAW)) begin
            if (new_string) begin
              cursor <= cfg.start_x;
              acc    <= '0;
            end
            state <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          if (!bad_q) begin
            acc <= acc + 16'(wsat6) + 16'd1;
          end
          state <= is_single ? S_SINGLE : S_REDUCE;
        end
        S_REDUCE: begin
          if (step == '0) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_load && emit_last) begin
            cursor <= cursor + 16'(width_q) + 16'd1;
            state  <= S_IDLE;
          end
        end
        S_SINGLE: begin
          if (out_load) begin
            if (!single_bad) begin
              cursor <= cursor + 16'(width_q) + 16'd1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    addr <= addr_next;
    if (accept) begin
      rel_q <= in_rel;
      bad_q <= in_bad;
    end
    if (state == S_LOOKUP) begin
      width_q    <= wsat6[WW-1:0];
      height_q   <= hsat6[HW-1:0];
      pages_q    <= pages3;
      red        <= offset_sel;
      div        <= DIV_INIT;
      step       <= STEP_W'(RED_STEPS);
      row        <= '0;
      col        <= '0;
      n          <= '0;
      xpos       <= cursor;
      ypos       <= cfg.start_y;
      single_bad <= bad_q;
    end
    if ((state == S_REDUCE) && (step != '0)) begin
      if (red_ge) begin
        red <= red_diff[OFF_W-1:0];
      end
      div  <= div >> 1;
      step <= step - STEP_W'(1);
    end
    if ((state == S_EMIT) && out_load && !emit_last) begin
      n <= n + CAP_W'(1);
      if (col_last) begin
        col  <= '0;
        row  <= row + 5'd1;
        xpos <= cursor;
        ypos <= ypos + 16'd1;
      end else begin
        col  <= col + 2'd1;
        xpos <= xpos + 16'(BITS_PER_BYTE);
      end
    end
    if (out_load) begin
      pixel_x      <= xpos;
      pixel_y      <= ypos;
      pixel_mask   <= (state == S_SINGLE) ? 8'd0 : gdata;
      pixel_color  <= cfg.draw_color;
      string_width <= sw;
      bad_char     <= (state == S_SINGLE) && single_bad;
      last         <= (state == S_SINGLE) || emit_last;
    end
  end

endmodule

// ===== design/bfgr_checker.sv =====
module bfgr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] pixel_x,
  input logic [7:0]  pixel_mask,
  input logic        bad_char,
  input logic        last
);
  import bfgr_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_x) &&
                                $stable(pixel_mask) && $stable(last))
    else $error("result changed while stalled");

  a_bad_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_char |-> last && (pixel_mask == 8'd0))
    else $error("bad character result not a single empty last item");

  a_busy_mid_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input taken in the middle of a character");

  a_draw_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (kind == KIND_DRAW) |=> !in_ready)
    else $error("ready right after a draw item");

endmodule

bind bitmap_font_glyph_renderer_top bfgr_checker u_bfgr_checker (.*);

// ===== tb/glyph_mask_checker.sv =====
`timescale 1ns / 1ps

module glyph_mask_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [bfgr_pkg::ADDR_W-1:0] paddr,
  input  logic [bfgr_pkg::DATA_W-1:0] pwdata,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [1:0]                  kind,
  input  logic [7:0]                  char_code,
  input  logic                        new_string,
  input  logic [6:0]                  entry_index,
  input  logic [4:0]                  entry_width,
  input  logic [11:0]                 entry_offset,
  input  logic [11:0]                 data_address,
  input  logic [7:0]                  data_byte,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [15:0]                 pixel_x,
  input  logic [15:0]                 pixel_y,
  input  logic [7:0]                  pixel_mask,
  input  logic [15:0]                 pixel_color,
  input  logic [15:0]                 string_width,
  input  logic                        bad_char,
  input  logic                        last,
  output int                          errors,
  output int                          pending,
  output int                          checked
);
  import bfgr_pkg::*;

  localparam int TABLE_DEPTH = 128;
  localparam int STORE_BYTES = 4096;
  localparam int MAX_H       = 16;
  localparam int MAX_W       = 16;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  mask;
    logic [15:0] color;
    logic [15:0] width;
    logic        bad;
    logic        last;
  } mask_beat_t;

  cfg_t        cfg;
  logic [15:0] cur_x;
  logic [15:0] str_acc;
  logic [4:0]  wtab [TABLE_DEPTH];
  logic [11:0] otab [TABLE_DEPTH];
  logic [7:0]  gstore [STORE_BYTES];
  mask_beat_t  mask_due [$];
  mask_beat_t  got;
  mask_beat_t  want;

  function automatic logic [15:0] shown_width();
    return (str_acc != 16'd0) ? str_acc - 16'd1 : 16'd0;
  endfunction

  task automatic render_char(input logic [7:0] code, input logic fresh);
    int rel, wd, off, ht, pages, total, n, a;
    mask_beat_t b;
    if (fresh) begin
      cur_x   = cfg.start_x;
      str_acc = 16'd0;
    end
    b = '0;
    b.color = cfg.draw_color;
    b.y     = cfg.start_y;
    if (code < cfg.first_char || int'(code) - int'(cfg.first_char) >= TABLE_DEPTH) begin
      b.x     = cur_x;
      b.width = shown_width();
      b.bad   = 1'b1;
      b.last  = 1'b1;
      mask_due.push_back(b);
      return;
    end
    rel = int'(code) - int'(cfg.first_char);
    if (cfg.use_char_table) begin
      wd  = wtab[rel];
      off = otab[rel];
    end else begin
      wd  = FIXED_WIDTH;
      off = rel * FIXED_WIDTH;
    end
    if (wd > MAX_W) wd = MAX_W;
    ht = cfg.font_height;
    if (ht > MAX_H) ht = MAX_H;
    pages   = (wd + BITS_PER_BYTE - 1) / BITS_PER_BYTE;
    str_acc = 16'(int'(str_acc) + wd + 1);
    b.width = shown_width();
    total   = pages * ht;
    if (total == 0) begin
      b.x    = cur_x;
      b.last = 1'b1;
      mask_due.push_back(b);
    end else begin
      if (total > RESULT_CAP) total = RESULT_CAP;
      n = 0;
      for (int row = 0; row < ht && n < total; row++) begin
        for (int col = 0; col < pages && n < total; col++) begin
          a      = (off + row * pages + col) % STORE_BYTES;
          b.x    = 16'(int'(cur_x) + col * BITS_PER_BYTE);
          b.y    = 16'(int'(cfg.start_y) + row);
          b.mask = gstore[a];
          n++;
          b.last = (n == total);
          mask_due.push_back(b);
        end
      end
    end
    cur_x = 16'(int'(cur_x) + wd + 1);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg                = '0;
      cfg.first_char     = FIRST_CHAR_RST;
      cfg.font_height    = FONT_HEIGHT_RST;
      cur_x              = 16'd0;
      str_acc            = 16'd0;
      errors             = 0;
      checked            = 0;
      mask_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_START_X:     cfg.start_x        = pwdata[15:0];
          REG_START_Y:     cfg.start_y        = pwdata[15:0];
          REG_DRAW_COLOR:  cfg.draw_color     = pwdata[15:0];
          REG_FIRST_CHAR:  cfg.first_char     = pwdata[7:0];
          REG_FONT_HEIGHT: cfg.font_height    = pwdata[4:0];
          REG_USE_TABLE:   cfg.use_char_table = pwdata[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{pixel_x, pixel_y, pixel_mask, pixel_color, string_width, bad_char, last};
        checked++;
        if (mask_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: x=%h y=%h mask=%h col=%h sw=%h bad=%b last=%b",
                     got.x, got.y, got.mask, got.color, got.width, got.bad, got.last);
        end else begin
          want = mask_due.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.mask !== want.mask ||
              got.color !== want.color || got.width !== want.width ||
              got.bad !== want.bad || got.last !== want.last) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: exp x=%h y=%h mask=%h col=%h sw=%h bad=%b last=%b",
                       want.x, want.y, want.mask, want.color, want.width, want.bad,
                       want.last);
              $display("          got x=%h y=%h mask=%h col=%h sw=%h bad=%b last=%b",
                       got.x, got.y, got.mask, got.color, got.width, got.bad, got.last);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        case (kind)
          KIND_LOAD_ENTRY: begin
            wtab[entry_index] = entry_width;
            otab[entry_index] = entry_offset;
          end
          KIND_LOAD_GLYPH: gstore[data_address] = data_byte;
          KIND_DRAW:       render_char(char_code, new_string);
          default: ;
        endcase
      end
    end
    pending = mask_due.size();
  end

endmodule

// ===== tb/bitmap_font_glyph_renderer_top_tb.sv =====
`timescale 1ns / 1ps

module bitmap_font_glyph_renderer_top_tb;
  import bfgr_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // table hits stay within these codes and glyph bytes
  localparam int LIVE_CODES = 8;
  localparam int LIVE_BYTES = 64;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  code;
    logic        fresh;
    logic [6:0]  idx;
    logic [4:0]  wd;
    logic [11:0] off;
    logic [11:0] addr;
    logic [7:0]  data;
  } glyph_item_t;

  logic              clk;
  logic              rst;
  logic              psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid, in_ready;
  logic [1:0]        kind;
  logic [7:0]        char_code;
  logic              new_string;
  logic [6:0]        entry_index;
  logic [4:0]        entry_width;
  logic [11:0]       entry_offset;
  logic [11:0]       data_address;
  logic [7:0]        data_byte;
  logic              out_valid, out_ready;
  logic [15:0]       pixel_x, pixel_y, pixel_color, string_width;
  logic [7:0]        pixel_mask;
  logic              bad_char, last;

  int   errors, pending, checked;
  int   items_sent, draws_sent, settings;
  logic calm;
  logic [7:0] first_now;

  bitmap_font_glyph_renderer_top uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .char_code(char_code), .new_string(new_string),
    .entry_index(entry_index), .entry_width(entry_width), .entry_offset(entry_offset),
    .data_address(data_address), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_mask(pixel_mask),
    .pixel_color(pixel_color), .string_width(string_width),
    .bad_char(bad_char), .last(last)
  );

  glyph_mask_checker chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .char_code(char_code), .new_string(new_string),
    .entry_index(entry_index), .entry_width(entry_width), .entry_offset(entry_offset),
    .data_address(data_address), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .pixel_mask(pixel_mask),
    .pixel_color(pixel_color), .string_width(string_width),
    .bad_char(bad_char), .last(last),
    .errors(errors), .pending(pending), .checked(checked)
  );

  always #10 clk = ~clk;

  // receiver stalls on about 12 percent of cycles, never while calm
  always @(negedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 12);
  end

  function automatic glyph_item_t any_item();
    glyph_item_t it;
    it.kind  = $urandom_range(0, 3);
    it.code  = $urandom_range(0, 255);
    it.fresh = $urandom_range(0, 1);
    it.idx   = $urandom_range(0, 127);
    it.wd    = $urandom_range(0, 31);
    it.off   = $urandom_range(0, 4095);
    it.addr  = $urandom_range(0, 4095);
    it.data  = $urandom_range(0, 255);
    return it;
  endfunction

  function automatic glyph_item_t draw_item(input int code, input bit fresh);
    glyph_item_t it;
    it       = any_item();
    it.kind  = KIND_DRAW;
    it.code  = code;
    it.fresh = fresh;
    return it;
  endfunction

  function automatic glyph_item_t entry_item(input int idx, input int wd, input int off);
    glyph_item_t it;
    it      = any_item();
    it.kind = KIND_LOAD_ENTRY;
    it.idx  = idx;
    it.wd   = wd;
    it.off  = off;
    return it;
  endfunction

  function automatic glyph_item_t glyph_item(input int addr, input int data);
    glyph_item_t it;
    it      = any_item();
    it.kind = KIND_LOAD_GLYPH;
    it.addr = addr;
    it.data = data;
    return it;
  endfunction

  function automatic int pick_width();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r < 3) return $urandom_range(17, 31);
    return $urandom_range(1, 16);
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // mostly loaded table codes, the rest random codes that hit no unloaded entry
  function automatic int pick_code();
    int span, code;
    span = 255 - int'(first_now);
    if (span > LIVE_CODES - 1) span = LIVE_CODES - 1;
    if ($urandom_range(0, 9) < 8) return int'(first_now) + $urandom_range(0, span);
    code = $urandom_range(0, 255);
    // move a table hit beyond the loaded codes to a code outside the table
    if (code >= int'(first_now) && code - int'(first_now) >= LIVE_CODES &&
        code - int'(first_now) < 128)
      return (first_now != 8'd0) ? int'(first_now) - 1 : code + 128;
    return code;
  endfunction

  task automatic send_item(input glyph_item_t it);
    if (!calm && $urandom_range(0, 99) < 12) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk);
    end
    @(negedge clk);
    kind         <= it.kind;
    char_code    <= it.code;
    new_string   <= it.fresh;
    entry_index  <= it.idx;
    entry_width  <= it.wd;
    entry_offset <= it.off;
    data_address <= it.addr;
    data_byte    <= it.data;
    in_valid     <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (it.kind == KIND_DRAW) draws_sent++;
  endtask

  // drain all results, then let a possible load finish
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (48) @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] reg_idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_regs(input logic [15:0] sx, input logic [15:0] sy,
                          input logic [15:0] color, input logic [7:0] fc,
                          input logic [4:0] fh, input logic tab);
    settle();
    apb_write(REG_START_X, sx);
    apb_write(REG_START_Y, sy);
    apb_write(REG_DRAW_COLOR, color);
    apb_write(REG_FIRST_CHAR, fc);
    apb_write(REG_FONT_HEIGHT, fh);
    apb_write(REG_USE_TABLE, tab);
    first_now = fc;
    settings++;
  endtask

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int calm_phase, r;
    logic [4:0] fh;
    logic [7:0] fc;
    glyph_item_t it;

    clk = 0; rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0;
    kind = '0; char_code = '0; new_string = 0; entry_index = '0; entry_width = '0;
    entry_offset = '0; data_address = '0; data_byte = '0;
    items_sent = 0; draws_sent = 0; settings = 0;
    calm = 1; first_now = FIRST_CHAR_RST;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // load every entry and glyph byte that a draw below can reach
    for (int i = 0; i < LIVE_CODES; i++)
      send_item(entry_item(i, pick_width(), $urandom_range(0, LIVE_BYTES - 32)));
    send_item(entry_item(127, pick_width(), $urandom_range(0, LIVE_BYTES - 32)));
    for (int i = 0; i < LIVE_BYTES; i++) send_item(glyph_item(i, $urandom_range(0, 255)));
    // fixed-width glyph of the last table code
    for (int i = 635; i < 651; i++) send_item(glyph_item(i, $urandom_range(0, 255)));
    // top of the store, reached by the wrapping entries
    for (int i = 4088; i < 4096; i++) send_item(glyph_item(i, $urandom_range(0, 255)));
    calm = 0;

    // fixed width five: first and last table code, codes outside, unused kind
    set_regs(16'h0000, 16'h0000, 16'hFFFF, 8'd32, 5'd8, 1'b0);
    send_item(draw_item(32, 1));
    send_item(draw_item(159, 0));
    send_item(draw_item(160, 0));
    send_item(draw_item(31, 0));
    send_item(draw_item(0, 1));
    send_item(draw_item(255, 0));
    it = any_item();
    it.kind = KIND_UNUSED;
    send_item(it);
    send_item(draw_item(39, 0));

    // table mode: zero width, widest, saturated width, address wrap
    send_item(entry_item(0, 0, 12'h123));
    send_item(entry_item(1, 16, 12'h000));
    send_item(entry_item(2, 31, 12'hFFF));
    send_item(entry_item(3, 9, 12'hFF8));
    send_item(glyph_item(12'hFFF, 8'hFF));
    send_item(glyph_item(12'h000, 8'h80));
    set_regs(16'hFFF8, 16'hFFF8, 16'h0000, 8'd0, 5'd16, 1'b1);
    send_item(draw_item(0, 1));
    send_item(draw_item(1, 0));
    send_item(draw_item(2, 0));
    send_item(draw_item(3, 0));
    send_item(draw_item(127, 0));
    send_item(draw_item(128, 0));

    // zero height, then height past the maximum
    set_regs(16'h1234, 16'h0040, 16'hA5A5, 8'd255, 5'd0, 1'b0);
    send_item(draw_item(255, 1));
    settle();
    apb_write(REG_FONT_HEIGHT, 5'd31);
    send_item(draw_item(255, 0));
    send_item(draw_item(254, 0));

    calm_phase = $urandom_range(0, 4);
    for (int p = 0; p < 5; p++) begin
      case ($urandom_range(0, 3))
        0:       fc = 8'd0;
        1:       fc = 8'd255;
        2:       fc = 8'd32;
        default: fc = $urandom_range(0, 255);
      endcase
      case ($urandom_range(0, 5))
        0:       fh = 5'd1;
        1:       fh = 5'd16;
        2:       fh = 5'd31;
        3:       fh = 5'd0;
        default: fh = $urandom_range(1, 16);
      endcase
      set_regs(pick16(), pick16(), pick16(), fc, fh, $urandom_range(0, 1));
      calm = (p == calm_phase);
      for (int i = 0; i < 16; i++) begin
        r  = $urandom_range(0, 99);
        it = any_item();
        if (r < 70) it = draw_item(pick_code(), $urandom_range(0, 4) == 0);
        else if (r < 85)
          it = entry_item($urandom_range(0, 127), pick_width(),
                          $urandom_range(0, LIVE_BYTES - 32));
        else if (r < 95) it.kind = KIND_LOAD_GLYPH;
        else it.kind = KIND_UNUSED;
        send_item(it);
      end
      calm = 0;
    end

    settle();
    $display("Sent %0d items (%0d draws) over %0d register settings", items_sent,
             draws_sent, settings);
    $display("Compared %0d mask results, %0d mismatches", checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
